// File: hw/rtl/lkv_pkg.sv
// Package for the linear key/value table: sizes, action and status codes,
// controller states and the command word broadcast to the entry cells.
// Used by lkv_cell and linear_key_value_table; depends on nothing.
package lkv_pkg;

    localparam int DEPTH  = 16;
    localparam int KEY_W  = 32;
    localparam int VAL_W  = 32;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;
    localparam int ACT_W  = 3;
    localparam int STAT_W = 2;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD        = 3'd0,
        ACT_REMOVE     = 3'd1,
        ACT_LOOKUP     = 3'd2,
        ACT_LOOKUP_INS = 3'd3,
        ACT_READ_AT    = 3'd4
    } t_action;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_NOT_FOUND = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_RANGE     = 2'd3
    } t_status;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } t_state;

    // Command broadcast to every cell during the execute cycle.
    typedef struct packed {
        logic             shift;
        logic             append;
        logic             update;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } t_cell_cmd;

endpackage

// File: hw/rtl/lkv_cell.sv
// One entry cell of the key/value table: holds a pair, compares it with the
// broadcast key and ripples the first-hit flag to its upper neighbor.
// Depends on lkv_pkg.
module lkv_cell (
    input  logic                     i_clk,
    input  lkv_pkg::t_cell_cmd       i_cmd,
    input  logic                     i_live,
    input  logic                     i_tail,
    input  logic                     i_hit_prior,
    input  logic [lkv_pkg::KEY_W-1:0] i_next_key,
    input  logic [lkv_pkg::VAL_W-1:0] i_next_value,
    output logic                     o_hit_after,
    output logic                     o_first,
    output logic [lkv_pkg::KEY_W-1:0] o_key,
    output logic [lkv_pkg::VAL_W-1:0] o_value
);
    import lkv_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;
    logic [KEY_W-1:0] n_key;
    logic [VAL_W-1:0] n_value;
    logic             w_match;

    assign w_match     = i_live && (r_key == i_cmd.key);
    assign o_first     = w_match && !i_hit_prior;
    assign o_hit_after = i_hit_prior || w_match;
    assign o_key       = r_key;
    assign o_value     = r_value;

    always_comb begin
        n_key   = r_key;
        n_value = r_value;
        if (i_cmd.update && o_first) begin
            n_value = i_cmd.value;
        end else if (i_cmd.append && i_tail) begin
            n_key   = i_cmd.key;
            n_value = i_cmd.value;
        end else if (i_cmd.shift && o_hit_after && i_live) begin
            // close the gap: take the pair of the upper neighbor
            n_key   = i_next_key;
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_value <= n_value;
    end

endmodule

// File: hw/rtl/linear_key_value_table.sv
// Top level of the linear key/value table: stream ports, two-state
// controller, result register and the row of lkv_cell entries.
// Depends on lkv_pkg and lkv_cell.
//
//  channel   dir  group              fields (lowest bit up)
//  --------  ---  -----------------  --------------------------------------------
//  request   in   i_s_axis_*         tuser: action; tdata: key, value, position
//  result    out  o_m_axis_*         tuser: status, found;
//                                    tdata: key_out, value_out, entry_position,
//                                    entry_count
//
// Every word is captured in the idle state; in the execute state all cells
// compare against the key in parallel, the first-hit flag ripples up the
// row, and the update, append or shift-down is written back together with
// the count. Synchronous active-low reset empties the table (count to zero);
// the cells hold no reset. A new word is taken only while the controller is
// idle and the result register is empty or being drained, so a stalled result
// side holds off the request side after at most one word.
module linear_key_value_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [71:0] i_s_axis_tdata,   // key[31:0], value[63:32], position[67:64], pad
    input  logic [2:0]  i_s_axis_tuser,   // action[2:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [79:0] o_m_axis_tdata,   // key_out[31:0], value_out[63:32],
                                          // entry_position[67:64], entry_count[72:68], pad
    output logic [2:0]  o_m_axis_tuser    // status[1:0], found[2]
);
    import lkv_pkg::*;

    // controller and captured request
    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    t_action            r_op;
    logic [KEY_W-1:0]   r_key;
    logic [VAL_W-1:0]   r_value;
    logic [IDX_W-1:0]   r_pos;
    logic               w_accept;
    logic               w_exec;

    // result register
    logic               r_out_valid;
    t_status            r_status;
    logic               r_found;
    logic [KEY_W-1:0]   r_key_out;
    logic [VAL_W-1:0]   r_value_out;
    logic [IDX_W-1:0]   r_epos;
    t_status            n_status;
    logic               n_found;
    logic [KEY_W-1:0]   n_key_out;
    logic [VAL_W-1:0]   n_value_out;
    logic [IDX_W-1:0]   n_epos;

    // cell row
    t_cell_cmd          w_cmd;
    logic [DEPTH-1:0]   w_live;
    logic [DEPTH-1:0]   w_tail;
    logic [DEPTH-1:0]   w_hit_after;
    logic [DEPTH-1:0]   w_first;
    logic [KEY_W-1:0]   w_cell_key   [DEPTH];
    logic [VAL_W-1:0]   w_cell_value [DEPTH];
    logic               w_hit_any;
    logic [IDX_W-1:0]   w_hit_idx;
    logic [VAL_W-1:0]   w_hit_value;
    logic               w_room;
    logic               w_pos_ok;

    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    // ---------------- controller ----------------
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_EXEC;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = 1'b0;
        w_exec          = 1'b0;
        unique case (r_state)
            ST_IDLE: o_s_axis_tready = !r_out_valid || i_m_axis_tready;
            ST_EXEC: w_exec = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (w_exec) r_count <= n_count;
        end
    end

    // capture the request word
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= t_action'(i_s_axis_tuser);
            r_key   <= i_s_axis_tdata[31:0];
            r_value <= i_s_axis_tdata[63:32];
            r_pos   <= i_s_axis_tdata[67:64];
        end
    end

    // ---------------- cell row ----------------
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++) begin : g_cell
            assign w_live[gi] = CNT_W'(gi) < r_count;
            assign w_tail[gi] = CNT_W'(gi) == r_count;
            if (gi == 0) begin : g_lo
                lkv_cell u_cell (
                    .i_clk        (i_clk),
                    .i_cmd        (w_cmd),
                    .i_live       (w_live[gi]),
                    .i_tail       (w_tail[gi]),
                    .i_hit_prior  (1'b0),
                    .i_next_key   (w_cell_key[gi+1]),
                    .i_next_value (w_cell_value[gi+1]),
                    .o_hit_after  (w_hit_after[gi]),
                    .o_first      (w_first[gi]),
                    .o_key        (w_cell_key[gi]),
                    .o_value      (w_cell_value[gi])
                );
            end else if (gi == DEPTH-1) begin : g_hi
                // the top cell has no upper neighbor: hold its own pair
                lkv_cell u_cell (
                    .i_clk        (i_clk),
                    .i_cmd        (w_cmd),
                    .i_live       (w_live[gi]),
                    .i_tail       (w_tail[gi]),
                    .i_hit_prior  (w_hit_after[gi-1]),
                    .i_next_key   (w_cell_key[gi]),
                    .i_next_value (w_cell_value[gi]),
                    .o_hit_after  (w_hit_after[gi]),
                    .o_first      (w_first[gi]),
                    .o_key        (w_cell_key[gi]),
                    .o_value      (w_cell_value[gi])
                );
            end else begin : g_mid
                lkv_cell u_cell (
                    .i_clk        (i_clk),
                    .i_cmd        (w_cmd),
                    .i_live       (w_live[gi]),
                    .i_tail       (w_tail[gi]),
                    .i_hit_prior  (w_hit_after[gi-1]),
                    .i_next_key   (w_cell_key[gi+1]),
                    .i_next_value (w_cell_value[gi+1]),
                    .o_hit_after  (w_hit_after[gi]),
                    .o_first      (w_first[gi]),
                    .o_key        (w_cell_key[gi]),
                    .o_value      (w_cell_value[gi])
                );
            end
        end
    endgenerate

    assign w_hit_any = w_hit_after[DEPTH-1];
    assign w_room    = r_count < CNT_W'(DEPTH);
    assign w_pos_ok  = {1'b0, r_pos} < r_count;

    // encode the one-hot first hit into a position and pick its value
    always_comb begin
        w_hit_idx   = '0;
        w_hit_value = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_first[i]) begin
                w_hit_idx   = w_hit_idx | IDX_W'(i);
                w_hit_value = w_hit_value | w_cell_value[i];
            end
        end
    end

    // command for the cells, live only in the execute cycle
    always_comb begin
        w_cmd.key    = r_key;
        w_cmd.value  = (r_op == ACT_ADD) ? r_value : '0;
        w_cmd.update = w_exec && (r_op == ACT_ADD);
        w_cmd.shift  = w_exec && (r_op == ACT_REMOVE);
        w_cmd.append = w_exec && ((r_op == ACT_ADD) || (r_op == ACT_LOOKUP_INS))
                       && !w_hit_any && w_room;
    end

    // ---------------- result ----------------
    always_comb begin
        n_status    = STAT_OK;
        n_found     = 1'b0;
        n_key_out   = '0;
        n_value_out = '0;
        n_epos      = '0;
        n_count     = r_count;
        case (r_op)
            ACT_ADD, ACT_LOOKUP_INS: begin
                if (w_hit_any) begin
                    n_found     = 1'b1;
                    n_value_out = (r_op == ACT_ADD) ? r_value : w_hit_value;
                    n_epos      = w_hit_idx;
                end else if (w_room) begin
                    n_value_out = w_cmd.value;
                    n_epos      = r_count[IDX_W-1:0];
                    n_count     = r_count + CNT_W'(1);
                end else begin
                    n_status = STAT_FULL;
                end
            end
            ACT_REMOVE: begin
                if (w_hit_any) begin
                    n_found     = 1'b1;
                    n_value_out = w_hit_value;
                    n_epos      = w_hit_idx;
                    n_count     = r_count - CNT_W'(1);
                end else begin
                    n_status = STAT_NOT_FOUND;
                end
            end
            ACT_LOOKUP: begin
                if (w_hit_any) begin
                    n_found     = 1'b1;
                    n_value_out = w_hit_value;
                    n_epos      = w_hit_idx;
                end else begin
                    n_status = STAT_NOT_FOUND;
                end
            end
            ACT_READ_AT: begin
                if (w_pos_ok) begin
                    n_key_out   = w_cell_key[r_pos];
                    n_value_out = w_cell_value[r_pos];
                    n_epos      = r_pos;
                end else begin
                    n_status = STAT_RANGE;
                end
            end
            default: ;  // unused codes: no operation
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_exec) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_status    <= n_status;
            r_found     <= n_found;
            r_key_out   <= n_key_out;
            r_value_out <= n_value_out;
            r_epos      <= n_epos;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = {r_found, r_status};
    assign o_m_axis_tdata  = {7'd0, r_count, r_epos, r_value_out, r_key_out};

endmodule

// File: verif/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for linear_key_value_table: directed and random requests,
// a table predictor, and stream-side stalls on both ports.
// Depends on lkv_pkg and the linear_key_value_table RTL.
module testbench;
    import lkv_pkg::*;

    // Action codes the block treats as no operation.
    localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
    localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

    localparam int RANDOM_WORDS = 900;
    localparam int EPOCH_LEN    = 48;
    localparam int KEY_POOL     = 24;     // more keys than slots, so the table can fill
    localparam int SETTLE       = 8;      // generous margin after the last result
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;
    localparam int S_PAD        = 72 - IDX_W - VAL_W - KEY_W;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED} t_mix;

    typedef struct {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [IDX_W-1:0] position;
    } t_table_request;

    typedef struct {
        t_status          status;
        logic             found;
        logic [KEY_W-1:0] key_out;
        logic [VAL_W-1:0] value_out;
        logic [IDX_W-1:0] entry_pos;
        logic [CNT_W-1:0] entry_count;
    } t_table_result;

    logic        i_clk;
    logic        i_rst_n         = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [71:0] i_s_axis_tdata  = '0;  // key, value, position, pad
    logic [2:0]  i_s_axis_tuser  = '0;  // action
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [79:0] o_m_axis_tdata;        // key_out, value_out, entry_position, entry_count, pad
    logic [2:0]  o_m_axis_tuser;        // status, found

    linear_key_value_table DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    t_table_request request_queue[$];
    t_table_result  pending_results[$];
    t_table_request in_flight;

    // Shadow copy of the table contents.
    logic [KEY_W-1:0] key_tbl[DEPTH];
    logic [VAL_W-1:0] val_tbl[DEPTH];
    int               entries = 0;

    int words_sent     = 0;
    int total_words    = 1;
    int mismatch_count = 0;
    int cycle_count    = 0;
    int full_seen      = 0;
    int missing_seen   = 0;
    int range_seen     = 0;
    int peak_entries   = 0;

    logic [KEY_W-1:0] key_pool[KEY_POOL];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Lowest slot holding the key, or -1 when absent.
    function automatic int find_key(logic [KEY_W-1:0] k);
        for (int i = 0; i < entries; i++)
            if (key_tbl[i] == k) return i;
        return -1;
    endfunction

    // Apply one request to the shadow table and return the result it must produce.
    function automatic t_table_result apply_request(t_table_request rq);
        t_table_result r;
        int            slot;
        r.status    = STAT_OK;
        r.found     = 1'b0;
        r.key_out   = '0;
        r.value_out = '0;
        r.entry_pos = '0;
        slot        = find_key(rq.key);
        case (rq.action)
            ACT_ADD, ACT_LOOKUP_INS: begin
                if (slot >= 0) begin
                    if (rq.action == ACT_ADD) val_tbl[slot] = rq.value;
                    r.found     = 1'b1;
                    r.value_out = val_tbl[slot];
                    r.entry_pos = slot[IDX_W-1:0];
                end else if (entries < DEPTH) begin
                    key_tbl[entries] = rq.key;
                    val_tbl[entries] = (rq.action == ACT_ADD) ? rq.value : '0;
                    r.value_out      = val_tbl[entries];
                    r.entry_pos      = entries[IDX_W-1:0];
                    entries++;
                end else begin
                    r.status = STAT_FULL;
                    full_seen++;
                end
            end
            ACT_REMOVE: begin
                if (slot >= 0) begin
                    r.found     = 1'b1;
                    r.value_out = val_tbl[slot];
                    r.entry_pos = slot[IDX_W-1:0];
                    // close the gap: everything above moves down one slot
                    for (int i = slot; i < entries - 1; i++) begin
                        key_tbl[i] = key_tbl[i+1];
                        val_tbl[i] = val_tbl[i+1];
                    end
                    entries--;
                end else begin
                    r.status = STAT_NOT_FOUND;
                    missing_seen++;
                end
            end
            ACT_LOOKUP: begin
                if (slot >= 0) begin
                    r.found     = 1'b1;
                    r.value_out = val_tbl[slot];
                    r.entry_pos = slot[IDX_W-1:0];
                end else begin
                    r.status = STAT_NOT_FOUND;
                    missing_seen++;
                end
            end
            ACT_READ_AT: begin
                if (int'(rq.position) < entries) begin
                    r.key_out   = key_tbl[rq.position];
                    r.value_out = val_tbl[rq.position];
                    r.entry_pos = rq.position;
                end else begin
                    r.status = STAT_RANGE;
                    range_seen++;
                end
            end
            default: ;
        endcase
        r.entry_count = entries[CNT_W-1:0];
        if (entries > peak_entries) peak_entries = entries;
        return r;
    endfunction

    task automatic push_request(logic [ACT_W-1:0] act, logic [KEY_W-1:0] k,
                                logic [VAL_W-1:0] v, logic [IDX_W-1:0] pos);
        t_table_request rq;
        rq.action   = act;
        rq.key      = k;
        rq.value    = v;
        rq.position = pos;
        request_queue.push_back(rq);
    endtask

    function automatic logic [VAL_W-1:0] pick_value();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 5) return '0;
        if (roll < 10) return '1;
        return $urandom();
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if ($urandom_range(0, 99) < 88) return key_pool[$urandom_range(0, KEY_POOL - 1)];
        return $urandom();
    endfunction

    // Weight the action mix so the table fills up, drains, or wanders.
    function automatic logic [ACT_W-1:0] pick_action(t_mix mix);
        int roll;
        int p_add, p_ins, p_rem, p_look, p_read;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:  begin p_add = 45; p_ins = 20; p_rem = 8;  p_look = 12; p_read = 12; end
            MIX_DRAIN: begin p_add = 12; p_ins = 8;  p_rem = 45; p_look = 15; p_read = 17; end
            default:   begin p_add = 25; p_ins = 12; p_rem = 25; p_look = 15; p_read = 20; end
        endcase
        if (roll < p_add) return ACT_ADD;
        roll -= p_add;
        if (roll < p_ins) return ACT_LOOKUP_INS;
        roll -= p_ins;
        if (roll < p_rem) return ACT_REMOVE;
        roll -= p_rem;
        if (roll < p_look) return ACT_LOOKUP;
        roll -= p_look;
        if (roll < p_read) return ACT_READ_AT;
        return ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
    endfunction

    // Stall percentages per third of the run: light sender/heavy receiver,
    // then swapped, then full throughput.
    function automatic int sender_idle_pct();
        case ((words_sent * 3) / total_words)
            0:       return 10;
            1:       return 57;
            default: return 0;
        endcase
    endfunction

    function automatic int receiver_idle_pct();
        case ((words_sent * 3) / total_words)
            0:       return 57;
            1:       return 10;
            default: return 0;
        endcase
    endfunction

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) $display("[%0t] MISMATCH %s", $realtime, what);
    endtask

    // Request driver: hold the word until it is taken, then predict its result.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            i_s_axis_tuser  <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pending_results.push_back(apply_request(in_flight));
                words_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (request_queue.size() != 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct()) begin
                    in_flight = request_queue.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {{S_PAD{1'b0}}, in_flight.position,
                                        in_flight.value, in_flight.key};
                    i_s_axis_tuser  <= in_flight.action;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each taken word with the oldest prediction.
    always @(posedge i_clk) begin : result_monitor
        t_table_result got;
        t_table_result want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.status      = t_status'(o_m_axis_tuser[1:0]);
                got.found       = o_m_axis_tuser[2];
                got.key_out     = o_m_axis_tdata[31:0];
                got.value_out   = o_m_axis_tdata[63:32];
                got.entry_pos   = o_m_axis_tdata[67:64];
                got.entry_count = o_m_axis_tdata[72:68];
                if (pending_results.size() == 0) begin
                    note_mismatch($sformatf("unexpected result: status %0d key_out %h value_out %h",
                                            got.status, got.key_out, got.value_out));
                end else begin
                    want = pending_results.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.key_out !== want.key_out || got.value_out !== want.value_out ||
                        got.entry_pos !== want.entry_pos ||
                        got.entry_count !== want.entry_count)
                        note_mismatch($sformatf({"exp st %0d f %0b k %h v %h pos %0d cnt %0d | ",
                                                 "got st %0d f %0b k %h v %h pos %0d cnt %0d"},
                                                want.status, want.found, want.key_out,
                                                want.value_out, want.entry_pos, want.entry_count,
                                                got.status, got.found, got.key_out,
                                                got.value_out, got.entry_pos, got.entry_count));
                end
            end
            i_m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct());
        end
    end

    // Watchdog on total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        t_mix             mix;
        logic [ACT_W-1:0] act;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < KEY_POOL; i++) key_pool[i] = $urandom();

        // Directed: empty-table misses, extreme keys and values, update in place,
        // insert-zero on miss and hit, reads in and out of range, spare codes,
        // removal from the middle and the head with the shift-down.
        push_request(ACT_LOOKUP,     32'h1234_5678, '0, '0);
        push_request(ACT_REMOVE,     32'h1234_5678, '0, '0);
        push_request(ACT_READ_AT,    '0, '0, '0);
        push_request(ACT_ADD,        '0, '1, '0);
        push_request(ACT_ADD,        '1, '0, '1);
        push_request(ACT_ADD,        '0, 32'h1234_5678, '0);
        push_request(ACT_LOOKUP_INS, 32'hA5A5_A5A5, 32'hFFFF_0000, '0);
        push_request(ACT_LOOKUP_INS, '0, 32'h5A5A_5A5A, '0);
        push_request(ACT_LOOKUP,     '1, '0, '0);
        push_request(ACT_READ_AT,    '0, '0, 4'd2);
        push_request(ACT_READ_AT,    '0, '0, '1);
        for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
            push_request(a[ACT_W-1:0], '1, '1, '1);
        push_request(ACT_REMOVE,     '1, '0, '0);
        push_request(ACT_READ_AT,    '0, '0, 4'd1);
        push_request(ACT_REMOVE,     '0, '0, '0);
        push_request(ACT_READ_AT,    '0, '0, '0);
        push_request(ACT_LOOKUP,     '0, '0, '0);

        // Random: epochs biased toward filling, draining or mixing; the first fills.
        mix = MIX_FILL;
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n != 0 && n % EPOCH_LEN == 0) mix = t_mix'($urandom_range(0, 2));
            act = pick_action(mix);
            push_request(act, pick_key(), pick_value(), IDX_W'($urandom_range(0, DEPTH - 1)));
        end
        total_words = request_queue.size();

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Hold until every word has been taken and every result has come back.
        wait (words_sent == total_words);
        wait (pending_results.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (pending_results.size() != 0)
            note_mismatch($sformatf("%0d results never arrived", pending_results.size()));

        $display("Ran %0d requests, table peaked at %0d of %0d entries.",
                 words_sent, peak_entries, DEPTH);
        $display("Saw %0d table-full, %0d missing-key and %0d out-of-range results; %0d mismatches.",
                 full_seen, missing_seen, range_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
